FILE: src/assert_macros.svh
// assertion macros used by the rtl top file
// no dependencies; take in by include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: src/rlqm_pkg.sv
// shared constants and the bar mapping for the rssi link quality monitor
// no dependencies
`default_nettype none

package rlqm_pkg;

	localparam int WINDOW_DEPTH_DEF = 8;
	localparam int RSSI_W           = 8;
	localparam int TICK_W           = 16;
	localparam int BAR_W            = 3;
	localparam int HELD_W           = 4;

	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd30000;
	localparam logic [TICK_W-1:0] IDLE_MAX      = 16'hFFFF;

	// apb register map: one register, index taken from paddr[2]
	localparam int          CFG_ADDR_W  = 3;
	localparam logic [0:0]  REG_TIMEOUT = 1'b0;

	// bar thresholds in dbm
	localparam logic signed [RSSI_W-1:0] BAR5_DBM = -8'sd50;
	localparam logic signed [RSSI_W-1:0] BAR4_DBM = -8'sd60;
	localparam logic signed [RSSI_W-1:0] BAR3_DBM = -8'sd70;
	localparam logic signed [RSSI_W-1:0] BAR2_DBM = -8'sd80;
	localparam logic signed [RSSI_W-1:0] BAR1_DBM = -8'sd90;

	function automatic logic [BAR_W-1:0] level_of(input logic signed [RSSI_W-1:0] dbm);
		logic [BAR_W-1:0] lvl;
		if (dbm >= BAR5_DBM)      lvl = 3'd5;
		else if (dbm >= BAR4_DBM) lvl = 3'd4;
		else if (dbm >= BAR3_DBM) lvl = 3'd3;
		else if (dbm >= BAR2_DBM) lvl = 3'd2;
		else if (dbm >= BAR1_DBM) lvl = 3'd1;
		else                      lvl = 3'd0;
		return lvl;
	endfunction

endpackage

`default_nettype wire

FILE: src/rlqm_in_if.sv
// input channel: one beat is a sample or a millisecond tick
// depends on rlqm_pkg
`default_nettype none

interface rlqm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 opcode;
	logic signed [rlqm_pkg::RSSI_W-1:0]   rssi_dbm;

	modport source (output valid, output opcode, output rssi_dbm, input ready);
	modport sink   (input valid, input opcode, input rssi_dbm, output ready);
endinterface

`default_nettype wire

FILE: src/rlqm_out_if.sv
// result channel: one beat per accepted input beat
// depends on rlqm_pkg
`default_nettype none

interface rlqm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [rlqm_pkg::RSSI_W-1:0]   smoothed_dbm;
	logic [rlqm_pkg::BAR_W-1:0]           bar_level;
	logic                                 link_active;
	logic                                 timed_out;
	logic [rlqm_pkg::HELD_W-1:0]          samples_held;

	modport source (output valid, output smoothed_dbm, output bar_level, output link_active,
		output timed_out, output samples_held, input ready);
	modport sink   (input valid, input smoothed_dbm, input bar_level, input link_active,
		input timed_out, input samples_held, output ready);
endinterface

`default_nettype wire

FILE: src/rlqm_divider.sv
// iterative restoring divider: signed total over unsigned sample count, one bit a cycle
// truncates toward zero; depends on rlqm_pkg
`default_nettype none

module rlqm_divider #(
	parameter int TOTAL_W = 11,
	parameter int FILL_W  = 4
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  signed [TOTAL_W-1:0]           dividend,
	input  wire         [FILL_W-1:0]            divisor,
	output logic                                busy,
	output logic                                done,
	output logic signed [rlqm_pkg::RSSI_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(TOTAL_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TOTAL_W-1:0] dvd_q;
	logic [FILL_W-1:0]  rem_q;
	logic [FILL_W-1:0]  dsr_q;
	logic               neg_q;

	logic [FILL_W:0]    rem_sh;
	logic               ge;
	logic [FILL_W:0]    rem_diff;
	logic [TOTAL_W-1:0] mag;
	logic [TOTAL_W-1:0] q_signed;

	assign mag      = dividend[TOTAL_W-1] ? TOTAL_W'(-dividend) : TOTAL_W'(dividend);
	assign rem_sh   = {rem_q, dvd_q[TOTAL_W-1]};
	assign ge       = rem_sh >= {1'b0, dsr_q};
	assign rem_diff = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TOTAL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[TOTAL_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TOTAL_W-2:0], ge};
			rem_q <= ge ? rem_diff[FILL_W-1:0] : rem_sh[FILL_W-1:0];
		end
	end

	assign q_signed = neg_q ? TOTAL_W'(-dvd_q) : dvd_q;
	assign quotient = signed'(q_signed[rlqm_pkg::RSSI_W-1:0]);
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

`default_nettype wire

FILE: src/rssi_link_quality_monitor_top.sv
// rssi link quality monitor: windowed moving average with warm-up, bars and timeout
// depends on rlqm_pkg, rlqm_in_if, rlqm_out_if, rlqm_divider, assert_macros.svh
//
// usage
//   sample_in carries one beat per event: opcode 0 is an rssi sample, opcode 1 a 1 ms tick.
//   result_out returns exactly one beat per input beat, in order.
//   apb port holds timeout_ticks at byte address 0 (reset 30000); user writes it only while idle, not enforced.
// processing
//   a sample runs through one shared adder (drop oldest once the window is full, add newest) and then a
//   one-bit-a-cycle divider over the total width before its result is registered.
//   a tick is handled in the accept cycle, then goes via the finish state to the output register.
//   sample_in.ready is high only while the sequencer sits idle; one beat in flight.
// reset
//   window empty, link inactive, average 0, idle tick count 0, timeout 30000.
//   ring contents are not cleared; a slot's old value is only used once the window is full.
// stalls
//   a finished result waits in the output register; the next beat can be accepted
//   and worked on meanwhile, and its result holds in the finish state until the
//   output register frees up.
`default_nettype none
`include "assert_macros.svh"

module rssi_link_quality_monitor_top #(
	parameter int WINDOW_DEPTH = rlqm_pkg::WINDOW_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	rlqm_in_if.sink                             sample_in,
	rlqm_out_if.source                          result_out,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [rlqm_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire  [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);

	localparam int RSSI_W  = rlqm_pkg::RSSI_W;
	localparam int TICK_W  = rlqm_pkg::TICK_W;
	localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int TOTAL_W = RSSI_W + $clog2(WINDOW_DEPTH);

	localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(WINDOW_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

	// sequencer codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SUB    = 3'd1;
	localparam logic [2:0] ST_ADD    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]                 state_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [FILL_W-1:0]          fill_q;
	logic signed [TOTAL_W-1:0]  total_q;
	logic signed [RSSI_W-1:0]   avg_q;
	logic                       active_q;
	logic [TICK_W-1:0]          idle_q;
	logic [TICK_W-1:0]          timeout_q;
	logic                       dropped_q;
	logic signed [RSSI_W-1:0]   new_q;
	logic signed [RSSI_W-1:0]   old_q;

	logic                       out_valid_q;
	logic signed [RSSI_W-1:0]   out_dbm_q;
	logic [rlqm_pkg::BAR_W-1:0] out_bar_q;
	logic                       out_active_q;
	logic                       out_drop_q;
	logic [rlqm_pkg::HELD_W-1:0] out_held_q;

	// sample ring, reset value undefined
	logic signed [RSSI_W-1:0]   ring_mem [WINDOW_DEPTH];

	logic                       in_fire;
	logic                       is_full;
	logic                       cfg_wr;
	logic [TICK_W-1:0]          idle_inc;
	logic                       drop_now;
	logic signed [TOTAL_W-1:0]  add_b;
	logic signed [TOTAL_W-1:0]  add_sum;
	logic [FILL_W-1:0]          fill_next;
	logic                       finish_load;
	logic [7:0]                 fill_ext;

	logic                       div_start;
	logic                       div_busy;
	logic                       div_done;
	logic signed [RSSI_W-1:0]   div_quot;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == rlqm_pkg::REG_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rlqm_pkg::TIMEOUT_RESET;
		end else if (cfg_wr && (paddr[2] == rlqm_pkg::REG_TIMEOUT)) begin
			timeout_q <= pwdata[TICK_W-1:0];
		end
	end

	// ---------------- handshake ----------------
	assign sample_in.ready = (state_q == ST_IDLE);
	assign in_fire         = sample_in.valid && sample_in.ready;
	assign finish_load     = (state_q == ST_FINISH) && (!out_valid_q || result_out.ready);

	// ---------------- tick path, resolved in the accept cycle ----------------
	assign idle_inc = (idle_q == rlqm_pkg::IDLE_MAX) ? idle_q : idle_q + 16'd1;
	assign drop_now = active_q && (idle_inc > timeout_q);

	// ---------------- shared adder: drop oldest, then add newest ----------------
	assign is_full   = (fill_q == FULL_CNT);
	assign add_b     = (state_q == ST_SUB) ? -TOTAL_W'(old_q) : TOTAL_W'(new_q);
	assign add_sum   = total_q + add_b;
	assign fill_next = is_full ? fill_q : fill_q + 1'b1;
	assign div_start = (state_q == ST_ADD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			slot_q    <= '0;
			fill_q    <= '0;
			total_q   <= '0;
			avg_q     <= '0;
			active_q  <= 1'b0;
			idle_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						dropped_q <= 1'b0;
						if (sample_in.opcode) begin
							idle_q <= idle_inc;
							if (drop_now) begin
								active_q  <= 1'b0;
								fill_q    <= '0;
								slot_q    <= '0;
								total_q   <= '0;
								dropped_q <= 1'b1;
							end
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SUB;
						end
					end
				end
				ST_SUB: begin
					if (is_full) begin
						total_q <= add_sum;
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					total_q  <= add_sum;
					fill_q   <= fill_next;
					slot_q   <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
					idle_q   <= '0;
					active_q <= 1'b1;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q   <= div_quot;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ring write in the add step, oldest entry read at accept
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			ring_mem[slot_q] <= new_q;
		end
		if (in_fire) begin
			old_q <= ring_mem[slot_q];
			new_q <= sample_in.rssi_dbm;
		end
	end

	rlqm_divider #(
		.TOTAL_W (TOTAL_W),
		.FILL_W  (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (add_sum),
		.divisor  (fill_next),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ---------------- output register ----------------
	assign fill_ext = 8'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_load) begin
			out_dbm_q    <= avg_q;
			out_bar_q    <= active_q ? rlqm_pkg::level_of(avg_q) : '0;
			out_active_q <= active_q;
			out_drop_q   <= dropped_q;
			out_held_q   <= fill_ext[rlqm_pkg::HELD_W-1:0];
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.smoothed_dbm = out_dbm_q;
	assign result_out.bar_level    = out_bar_q;
	assign result_out.link_active  = out_active_q;
	assign result_out.timed_out    = out_drop_q;
	assign result_out.samples_held = out_held_q;

	// ---------------- assertions ----------------
	`ASSERT_IMPLIES(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FULL_CNT)
	`ASSERT_IMPLIES(a_no_accept_while_dividing, clk, arst_n, div_busy, !sample_in.ready)
	`ASSERT_IMPLIES(a_drop_clears_window, clk, arst_n, dropped_q && state_q == ST_FINISH, fill_q == '0 && !active_q)
	`ASSERT_NEXT(a_sample_goes_active, clk, arst_n, state_q == ST_ADD, active_q && idle_q == '0)

endmodule

`default_nettype wire
